// File: hdl/gbn_pkg.sv
// Package for the go-back-N sender window: sizes, codes and transfer types.
// Used by gbn_slots and go_back_n_sender_window_top.
package gbn_pkg;

  localparam int unsigned WINDOW      = 32;
  localparam int unsigned MAX_RESULTS = 32;
  // a resend run never covers more than this many packets
  localparam int unsigned RUN_CAP     = (MAX_RESULTS < WINDOW) ? MAX_RESULTS : WINDOW;

  localparam int unsigned SLOT_W     = $clog2(WINDOW);
  localparam int unsigned CNT_W      = $clog2(WINDOW + 1);
  localparam int unsigned SEQ_W      = 16;
  localparam int unsigned SIZE_W     = 8;
  localparam int unsigned TICK_W     = 32;
  localparam int unsigned MISS_W     = 4;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [TICK_W-1:0] TIMEOUT_RST = 32'd600;
  localparam logic [MISS_W-1:0] MISS_RST    = 4'd3;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_ACK  = 2'd1,
    KIND_TICK = 2'd2
  } in_kind_e;

  typedef enum logic [1:0] {
    OK_NEW     = 2'd0,
    OK_RETX    = 2'd1,
    OK_REFUSED = 2'd2,
    OK_STATUS  = 2'd3
  } out_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIMEOUT    = 1'b0,
    REG_MISS_LIMIT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]        kind;
    logic [SIZE_W-1:0] data_size;
    logic [SEQ_W-1:0]  ack_seq;
  } gbn_in_t;

  typedef struct packed {
    out_kind_e         out_kind;
    logic [SEQ_W-1:0]  seq_num;
    logic [SIZE_W-1:0] pkt_size;
    logic              done_res;
    logic              last;
  } gbn_out_t;

  // access request to the slot store, offsets relative to the slot of the window base
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] wr_ofs;
    logic [SIZE_W-1:0] wr_size;
    logic              re;
    logic [SLOT_W-1:0] rd_ofs;
  } gbn_slot_req_t;

endpackage

// File: hdl/gbn_slots.sv
// Slot size store: one synchronous memory with one write and one registered read.
// Turns offsets from the head slot into addresses. Depends on gbn_pkg.
module gbn_slots (
  input  logic                          clk_i,
  input  logic [gbn_pkg::SLOT_W-1:0]    head_i,
  input  gbn_pkg::gbn_slot_req_t        req_i,
  output logic [gbn_pkg::SIZE_W-1:0]    rd_size_o
);
  import gbn_pkg::*;

  localparam logic [SLOT_W:0] WIN_S = (SLOT_W + 1)'(WINDOW);

  logic [SIZE_W-1:0] mem [WINDOW];
  logic [SIZE_W-1:0] rd_size_q;
  logic [SLOT_W:0]   wr_sum, rd_sum;
  logic [SLOT_W-1:0] wr_addr, rd_addr;

  // head + offset modulo the window; both terms are below the window
  always_comb begin
    wr_sum  = {1'b0, head_i} + {1'b0, req_i.wr_ofs};
    rd_sum  = {1'b0, head_i} + {1'b0, req_i.rd_ofs};
    wr_addr = (wr_sum >= WIN_S) ? SLOT_W'(wr_sum - WIN_S) : wr_sum[SLOT_W-1:0];
    rd_addr = (rd_sum >= WIN_S) ? SLOT_W'(rd_sum - WIN_S) : rd_sum[SLOT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[wr_addr] <= req_i.wr_size;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_size_q <= mem[rd_addr];
    end
  end

  assign rd_size_o = rd_size_q;

endmodule

// File: hdl/go_back_n_sender_window_top.sv
// Go-back-N sender window top level: window state, resend sequencer, output register.
// Depends on gbn_pkg and gbn_slots.
//
//  channel | signals                                 | transfer when
//  --------+-----------------------------------------+-------------------------
//  input   | in_valid_i, in_ready_o, in_data_i       | in_valid_i & in_ready_o
//  output  | out_valid_o, out_ready_i, out_data_o    | out_valid_o & out_ready_i
//  config  | cfg_we_i, cfg_idx_i, cfg_wdata_i        | cfg_we_i
//
// Sends, acks and ticks give their single result the next cycle unless an ack or tick
// starts a resend run, which reads the slot store once per packet and holds off input
// until its last packet is loaded; a pending stage covers the registered memory read.
// Output stalls stall the run; in idle, input is taken whenever the output can drain.
// Reset clears the window, timer, miss count and flags; the slot store is not cleared.
module go_back_n_sender_window_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  gbn_pkg::gbn_in_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output gbn_pkg::gbn_out_t               out_data_o,
  input  logic                            cfg_we_i,
  input  logic [gbn_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [gbn_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import gbn_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  localparam logic [CNT_W-1:0]  WIN_C  = CNT_W'(WINDOW);
  localparam logic [CNT_W-1:0]  CAP_C  = CNT_W'(RUN_CAP);
  localparam logic [SLOT_W-1:0] HEAD_MAX = SLOT_W'(WINDOW - 1);

  state_e            state_q, state_d;
  logic [TICK_W-1:0] timeout_q;
  logic [MISS_W-1:0] miss_limit_q;
  logic [SEQ_W-1:0]  base_q, base_d, next_q, next_d;
  logic [SLOT_W-1:0] head_q, head_d;
  logic [TICK_W-1:0] tick_q, tick_d;
  logic [MISS_W-1:0] miss_q, miss_d;
  logic              end_q, end_d, fin_q, fin_d;
  logic [CNT_W-1:0]  run_len_q, run_len_d, run_idx_q, run_idx_d;
  logic              pend_q, pend_d, pend_last_q, pend_last_d;
  logic [SEQ_W-1:0]  pend_seq_q, pend_seq_d;
  logic              out_valid_q, out_valid_d;
  gbn_out_t          out_q, out_d;

  logic              in_fire, out_free, can_load, issue;
  logic [SEQ_W-1:0]  diff;
  logic [CNT_W-1:0]  n_out;
  logic [MISS_W-1:0] miss_new;
  logic [TICK_W-1:0] tick_new;
  logic              resend, status;
  gbn_slot_req_t     slot_req;
  logic [SIZE_W-1:0] rd_size;

  gbn_slots u_slots (
    .clk_i     (clk_i),
    .head_i    (head_q),
    .req_i     (slot_req),
    .rd_size_o (rd_size)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;
  assign diff       = next_q - base_q;
  assign n_out      = diff[CNT_W-1:0];

  // resend run: a read is in flight (pend) while the next is issued behind it
  assign can_load = (state_q == ST_RUN) && pend_q && out_free;
  assign issue    = (state_q == ST_RUN) && (run_idx_q != run_len_q) && (!pend_q || can_load);

  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    next_d      = next_q;
    head_d      = head_q;
    tick_d      = tick_q;
    miss_d      = miss_q;
    end_d       = end_q;
    fin_d       = fin_q;
    run_len_d   = run_len_q;
    run_idx_d   = run_idx_q;
    pend_d      = pend_q;
    pend_last_d = pend_last_q;
    pend_seq_d  = pend_seq_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    resend      = 1'b0;
    status      = 1'b1;
    miss_new    = (miss_q == '1) ? miss_q : miss_q + 1'b1;
    tick_new    = (tick_q == '1) ? tick_q : tick_q + 1'b1;
    slot_req    = '0;
    slot_req.wr_ofs  = n_out[SLOT_W-1:0];
    slot_req.wr_size = in_data_i.data_size;
    slot_req.rd_ofs  = run_idx_q[SLOT_W-1:0];

    if (in_fire) begin
      case (in_data_i.kind)
        KIND_DATA: begin
          status          = 1'b0;
          out_d.out_kind  = OK_REFUSED;
          out_d.seq_num   = next_q;
          out_d.pkt_size  = in_data_i.data_size;
          if (!end_q && (n_out < WIN_C)) begin
            if (n_out == '0) begin
              tick_d = '0;
            end
            slot_req.we    = 1'b1;
            out_d.out_kind = OK_NEW;
            next_d         = next_q + 1'b1;
            if (in_data_i.data_size == '0) begin
              end_d = 1'b1;
            end
          end
        end
        KIND_ACK: begin
          if (n_out != '0) begin
            if (in_data_i.ack_seq == base_q) begin
              base_d = base_q + 1'b1;
              head_d = (head_q == HEAD_MAX) ? '0 : head_q + 1'b1;
              tick_d = '0;
              if ((base_d == next_q) && end_q) begin
                fin_d = 1'b1;
              end
            end else begin
              miss_d = miss_new;
              resend = (tick_q >= timeout_q) || (miss_new >= miss_limit_q);
            end
          end
        end
        KIND_TICK: begin
          tick_d = tick_new;
          resend = (tick_new >= timeout_q) || (miss_q >= miss_limit_q);
        end
        default: ;
      endcase

      if (resend) begin
        miss_d = '0;
        tick_d = '0;
        if (n_out != '0) begin
          status    = 1'b0;
          state_d   = ST_RUN;
          run_len_d = (n_out > CAP_C) ? CAP_C : n_out;
          run_idx_d = '0;
          pend_d    = 1'b0;
        end
      end

      if (status) begin
        out_d.out_kind = OK_STATUS;
        out_d.seq_num  = base_d;
        out_d.pkt_size = '0;
      end
      out_d.done_res = fin_d;
      out_d.last     = 1'b1;
      if (state_d == ST_IDLE) begin
        out_valid_d = 1'b1;
      end
    end

    if (issue) begin
      slot_req.re = 1'b1;
      run_idx_d   = run_idx_q + 1'b1;
      pend_seq_d  = base_q + SEQ_W'(run_idx_q);
      pend_last_d = (run_idx_q == run_len_q - 1'b1);
    end
    if (issue) begin
      pend_d = 1'b1;
    end else if (can_load) begin
      pend_d = 1'b0;
    end

    if (can_load) begin
      out_valid_d    = 1'b1;
      out_d.out_kind = OK_RETX;
      out_d.seq_num  = pend_seq_q;
      out_d.pkt_size = rd_size;
      out_d.done_res = fin_q;
      out_d.last     = pend_last_q;
      if (pend_last_q) begin
        state_d = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      timeout_q    <= TIMEOUT_RST;
      miss_limit_q <= MISS_RST;
      base_q       <= '0;
      next_q       <= '0;
      head_q       <= '0;
      tick_q       <= '0;
      miss_q       <= '0;
      end_q        <= 1'b0;
      fin_q        <= 1'b0;
      run_len_q    <= '0;
      run_idx_q    <= '0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      next_q      <= next_d;
      head_q      <= head_d;
      tick_q      <= tick_d;
      miss_q      <= miss_d;
      end_q       <= end_d;
      fin_q       <= fin_d;
      run_len_q   <= run_len_d;
      run_idx_q   <= run_idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TIMEOUT:    timeout_q    <= cfg_wdata_i[TICK_W-1:0];
          REG_MISS_LIMIT: miss_limit_q <= cfg_wdata_i[MISS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_seq_q  <= pend_seq_d;
    pend_last_q <= pend_last_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_window_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_out <= WIN_C)
    else $error("outstanding count beyond window");

  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> (run_idx_q < run_len_q) && (run_len_q <= CAP_C))
    else $error("slot read beyond run length");

  a_run_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (can_load && pend_last_q) |=> (state_q == ST_IDLE) && out_valid_q && out_q.last)
    else $error("run did not end on its last transfer");

  a_finished: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> end_q && (base_q == next_q))
    else $error("finished with packets outstanding");
`endif

endmodule
